// ===== design/euler_fly_camera_update_unit_assert.svh =====
// Assertion macros for the fly camera update unit.
// Included by the top level; needs nothing else.
`ifndef EULER_FLY_CAMERA_UPDATE_UNIT_ASSERT_SVH
`define EULER_FLY_CAMERA_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication
`define EFCU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fly camera check failed");

// next-cycle implication
`define EFCU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fly camera check failed");

`endif

// ===== design/efcu_pkg.sv =====
// Shared types, constants and tables of the fly camera update unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package efcu_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int CordicIters  = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int IterW        = (CordicIters > 1) ? $clog2(CordicIters) : 1;

   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [26:0] HALF_TURN   = 27'sd11796480;  // 180 deg Q.16
   localparam logic signed [26:0] FULL_TURN   = 27'sd23592960;  // 360 deg Q.16
   localparam logic signed [26:0] QUARTER     = 27'sd5898240;   // 90 deg Q.16
   localparam logic signed [34:0] PITCH_LIMIT = 35'sd22784;
   localparam logic signed [34:0] YAW_LIMIT   = 35'sd92160;
   localparam logic signed [15:0] UNIT_Q14    = 16'sd16384;

   localparam logic [15:0] SPEED_RESET = 16'd5120;
   localparam logic [15:0] SENS_RESET  = 16'd6400;
   localparam logic signed [17:0] YAW_RESET = -18'sd23040;

   // register index codes (byte address / 4)
   localparam logic REG_MOVE_SPEED = 1'b0;
   localparam logic REG_LOOK_SENS  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_ACC, ST_ANGLE, ST_CINIT, ST_CITER, ST_CEND, ST_RESP
   } state_type;

   typedef enum logic [3:0] {
      MOP_STEP, MOP_MOVE, MOP_DXS, MOP_DXT, MOP_DYS, MOP_DYT,
      MOP_CYCP, MOP_SYCP, MOP_CYSP, MOP_SYSP
   } mop_type;

   // arctangent of 2^-i in Q.16 degrees
   function automatic logic [21:0] atan_q16(input logic [4:0] idx);
      logic [21:0] v;
      case (idx)
         5'd0:  v = 22'd2949120;
         5'd1:  v = 22'd1740967;
         5'd2:  v = 22'd919879;
         5'd3:  v = 22'd466945;
         5'd4:  v = 22'd234379;
         5'd5:  v = 22'd117305;
         5'd6:  v = 22'd58666;
         5'd7:  v = 22'd29335;
         5'd8:  v = 22'd14668;
         5'd9:  v = 22'd7334;
         5'd10: v = 22'd3667;
         5'd11: v = 22'd1833;
         5'd12: v = 22'd917;
         5'd13: v = 22'd458;
         5'd14: v = 22'd229;
         5'd15: v = 22'd115;
         5'd16: v = 22'd57;
         5'd17: v = 22'd29;
         5'd18: v = 22'd14;
         5'd19: v = 22'd7;
         5'd20: v = 22'd4;
         5'd21: v = 22'd2;
         5'd22: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

   // clamp a rounded Q1.14 value to +-1.0
   function automatic logic signed [15:0] clamp_unit(input logic signed [35:0] v);
      logic signed [15:0] r;
      if (v > 36'sd16384)
         r = UNIT_Q14;
      else if (v < -36'sd16384)
         r = -UNIT_Q14;
      else
         r = v[15:0];
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/euler_fly_camera_update_unit.sv =====
// Fly camera update: position step, pitch/yaw update, CORDIC basis rebuild.
// Depends on efcu_pkg and euler_fly_camera_update_unit_assert.svh.
//
//   port group | dir | role
//   req_*      | in  | one frame item per handshake
//   rsp_*      | out | camera state after the item, registered
//   csr_*      | in  | APB register port (move_speed, look_sensitivity)
//
// One shared 33x17 multiplier handles 18 products, each in an ST_MUL and an ST_ACC
// state. One CORDIC unit runs twice, CORDIC_STEPS iterations plus setup and finish.
// ST_ANGLE does the angle update and ST_RESP loads the result.
// req_tready is high only when the sequencer is idle; the result register lets a
// new item start while the previous result still waits.
// Synchronous active-high reset restores the power-up camera and registers.
`timescale 1ns / 1ps
`default_nettype none
`include "euler_fly_camera_update_unit_assert.svh"

module euler_fly_camera_update_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // forward_axis[1:0], strafe_axis[3:2], rise_axis[5:4], mouse_dx[21:6],
   // mouse_dy[37:22], frame_time[53:38], zero pad
   input  wire logic [55:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // pos_x[31:0], pos_y[63:32], pos_z[95:64], fwd_x[111:96], fwd_y[127:112],
   // fwd_z[143:128], up_x[159:144], up_y[175:160], up_z[191:176],
   // yaw_angle[209:192], pitch_angle[225:210], zero pad
   output logic [231:0]      rsp_tdata,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import efcu_pkg::*;

   state_type state_ff, state_in;
   mop_type   op_ff, op_in;
   logic [1:0] comp_ff, comp_in, vec_ff, vec_in;
   logic [IterW-1:0] iter_ff, iter_in;
   logic sel_ff, sel_in, flip_ff, flip_in;

   logic [15:0] speed_ff, sens_ff;
   logic signed [1:0] dir_ff [3];
   logic signed [1:0] dir_in [3];
   logic signed [15:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [15:0] t_ff, t_in;

   logic [31:0] step_ff, step_in;
   logic signed [49:0] prod_ff, prod_in;
   logic signed [33:0] acc_ff, acc_in;
   logic signed [32:0] tmp_ff, tmp_in;
   logic signed [33:0] offx_ff, offx_in, offy_ff, offy_in;

   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];
   logic signed [17:0] yaw_ff, yaw_in;
   logic signed [15:0] pitch_ff, pitch_in;
   logic signed [15:0] basis_ff [9];
   logic signed [15:0] basis_in [9];
   logic signed [15:0] sy_ff, sy_in, cy_ff, cy_in, sp_ff, sp_in, cp_ff, cp_in;

   logic signed [32:0] crx_ff, crx_in, cry_ff, cry_in;
   logic signed [25:0] crz_ff, crz_in;

   logic         rsp_tvalid_ff, rsp_tvalid_in;
   logic [231:0] rsp_tdata_ff, rsp_tdata_in;

   logic signed [32:0] mul_a;
   logic signed [16:0] mul_b;
   logic [3:0]         bidx;
   logic signed [15:0] bsel;

   logic csr_wr;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_LOOK_SENS) ? {16'd0, sens_ff} : {16'd0, speed_ff};

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // basis element feeding the current move product
   assign bidx = 4'({2'b00, vec_ff} * 4'd3) + {2'b00, comp_ff};
   assign bsel = basis_ff[bidx];

   // shared multiplier operand select
   always_comb begin
      case (op_ff)
         MOP_STEP: begin mul_a = {17'd0, speed_ff};        mul_b = {1'b0, t_ff};    end
         MOP_MOVE: begin mul_a = {1'b0, step_ff};          mul_b = 17'(bsel);       end
         MOP_DXS:  begin mul_a = 33'(dx_ff);               mul_b = {1'b0, sens_ff}; end
         MOP_DYS:  begin mul_a = 33'(dy_ff);               mul_b = {1'b0, sens_ff}; end
         MOP_DXT,
         MOP_DYT:  begin mul_a = tmp_ff;                   mul_b = {1'b0, t_ff};    end
         MOP_CYCP: begin mul_a = 33'(cy_ff);               mul_b = 17'(cp_ff);      end
         MOP_SYCP: begin mul_a = 33'(sy_ff);               mul_b = 17'(cp_ff);      end
         MOP_CYSP: begin mul_a = 33'(cy_ff);               mul_b = 17'(sp_ff);      end
         MOP_SYSP: begin mul_a = 33'(sy_ff);               mul_b = 17'(sp_ff);      end
         default:  begin mul_a = '0;                       mul_b = '0;              end
      endcase
   end

   // sequencer and datapath next values
   always_comb begin
      logic signed [49:0] r22, r16, r14;
      logic signed [27:0] term;
      logic signed [33:0] base, sum;
      logic signed [15:0] q14;
      logic signed [34:0] pnew, ynew;
      logic signed [17:0] deg;
      logic signed [26:0] zw;
      logic signed [32:0] xs, ys, xf, yf;
      logic signed [25:0] at;
      logic signed [16:0] rx, ry;

      state_in = state_ff;  op_in = op_ff;  comp_in = comp_ff;  vec_in = vec_ff;
      iter_in = iter_ff;    sel_in = sel_ff; flip_in = flip_ff;
      dir_in = dir_ff;  dx_in = dx_ff;  dy_in = dy_ff;  t_in = t_ff;
      step_in = step_ff;  acc_in = acc_ff;  tmp_in = tmp_ff;
      offx_in = offx_ff;  offy_in = offy_ff;
      pos_in = pos_ff;  yaw_in = yaw_ff;  pitch_in = pitch_ff;  basis_in = basis_ff;
      sy_in = sy_ff;  cy_in = cy_ff;  sp_in = sp_ff;  cp_in = cp_ff;
      crx_in = crx_ff;  cry_in = cry_ff;  crz_in = crz_ff;
      rsp_tvalid_in = rsp_tvalid_ff;  rsp_tdata_in = rsp_tdata_ff;
      prod_in = mul_a * mul_b;

      // rounding views of the product
      r22  = (prod_ff + 50'sd2097152) >>> 22;
      r16  = (prod_ff + 50'sd32768) >>> 16;
      r14  = (prod_ff + 50'sd8192) >>> 14;
      term = r22[27:0];
      q14  = clamp_unit(r14[35:0]);
      base = (vec_ff == 2'd0) ? 34'(pos_ff[comp_ff]) : acc_ff;
      case (dir_ff[vec_ff])
         2'sb01:  sum = base + 34'(term);
         2'sb11:  sum = base - 34'(term);
         default: sum = base;
      endcase

      pnew = 35'(pitch_ff) - 35'(offy_ff);
      ynew = 35'(yaw_ff) + 35'(offx_ff);

      // CORDIC angle wrap into [-180, 180]; ST_CINIT folds it into [-90, 90]
      deg = sel_ff ? 18'(pitch_ff) : yaw_ff;
      zw  = 27'($signed({deg, 8'd0}));
      if (zw > HALF_TURN)
         zw = zw - FULL_TURN;
      else if (zw < -HALF_TURN)
         zw = zw + FULL_TURN;

      xs = crx_ff >>> iter_ff;
      ys = cry_ff >>> iter_ff;
      at = 26'(atan_q16(5'(iter_ff)));
      xf = flip_ff ? -crx_ff : crx_ff;
      yf = flip_ff ? -cry_ff : cry_ff;
      rx = 17'((xf + 33'sd32768) >>> 16);
      ry = 17'((yf + 33'sd32768) >>> 16);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               for (int i = 0; i < 3; i++) begin
                  case (req_tdata[2*i +: 2])
                     2'b01:   dir_in[i] = 2'sb01;
                     2'b00:   dir_in[i] = 2'sb00;
                     default: dir_in[i] = 2'sb11;
                  endcase
               end
               dx_in    = req_tdata[21:6];
               dy_in    = req_tdata[37:22];
               t_in     = req_tdata[53:38];
               op_in    = MOP_STEP;
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            state_in = ST_MUL;
            case (op_ff)
               MOP_STEP: begin
                  step_in = prod_ff[31:0];
                  op_in = MOP_MOVE;  comp_in = 2'd0;  vec_in = 2'd0;
               end
               MOP_MOVE: begin
                  if (vec_ff == 2'd2) begin
                     // saturate the finished component
                     if (sum > 34'sd2147483647)
                        pos_in[comp_ff] = 32'sh7FFFFFFF;
                     else if (sum < -34'sd2147483648)
                        pos_in[comp_ff] = 32'sh80000000;
                     else
                        pos_in[comp_ff] = sum[31:0];
                     vec_in = 2'd0;
                     if (comp_ff == 2'd2)
                        op_in = MOP_DXS;
                     else
                        comp_in = comp_ff + 2'd1;
                  end else begin
                     acc_in = sum;
                     vec_in = vec_ff + 2'd1;
                  end
               end
               MOP_DXS: begin tmp_in = prod_ff[32:0]; op_in = MOP_DXT; end
               MOP_DXT: begin offx_in = r16[33:0];    op_in = MOP_DYS; end
               MOP_DYS: begin tmp_in = prod_ff[32:0]; op_in = MOP_DYT; end
               MOP_DYT: begin offy_in = r16[33:0];    state_in = ST_ANGLE; end
               MOP_CYCP: begin basis_in[0] = q14;  op_in = MOP_SYCP; end
               MOP_SYCP: begin basis_in[2] = q14;  op_in = MOP_CYSP; end
               MOP_CYSP: begin basis_in[6] = -q14; op_in = MOP_SYSP; end
               MOP_SYSP: begin
                  basis_in[8] = -q14;
                  basis_in[1] = sp_ff;  basis_in[3] = -sy_ff;  basis_in[4] = 16'sd0;
                  basis_in[5] = cy_ff;  basis_in[7] = cp_ff;
                  state_in = ST_RESP;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_ANGLE: begin
            // pitch clamp, yaw set to zero when out of range
            if (pnew > PITCH_LIMIT)
               pitch_in = 16'(PITCH_LIMIT);
            else if (pnew < -PITCH_LIMIT)
               pitch_in = 16'(-PITCH_LIMIT);
            else
               pitch_in = pnew[15:0];
            if (ynew > YAW_LIMIT || ynew < -YAW_LIMIT)
               yaw_in = 18'sd0;
            else
               yaw_in = ynew[17:0];
            sel_in   = 1'b0;
            state_in = ST_CINIT;
         end
         ST_CINIT: begin
            flip_in = 1'b0;
            if (zw > QUARTER) begin
               zw = zw - HALF_TURN;  flip_in = 1'b1;
            end else if (zw < -QUARTER) begin
               zw = zw + HALF_TURN;  flip_in = 1'b1;
            end
            crz_in   = zw[25:0];
            crx_in   = CORDIC_GAIN;
            cry_in   = 33'sd0;
            iter_in  = '0;
            state_in = ST_CITER;
         end
         ST_CITER: begin
            if (crz_ff >= 26'sd0) begin
               crx_in = crx_ff - ys;  cry_in = cry_ff + xs;  crz_in = crz_ff - at;
            end else begin
               crx_in = crx_ff + ys;  cry_in = cry_ff - xs;  crz_in = crz_ff + at;
            end
            if (iter_ff == IterW'(CordicIters - 1))
               state_in = ST_CEND;
            else
               iter_in = iter_ff + 1'b1;
         end
         ST_CEND: begin
            if (sel_ff) begin
               cp_in = clamp_unit(36'(rx));
               sp_in = clamp_unit(36'(ry));
               op_in = MOP_CYCP;
               state_in = ST_MUL;
            end else begin
               cy_in = clamp_unit(36'(rx));
               sy_in = clamp_unit(36'(ry));
               sel_in = 1'b1;
               state_in = ST_CINIT;
            end
         end
         ST_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in = {6'd0, pitch_ff, yaw_ff,
                               basis_ff[8], basis_ff[7], basis_ff[6],
                               basis_ff[2], basis_ff[1], basis_ff[0],
                               pos_ff[2], pos_ff[1], pos_ff[0]};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // result taken without a new one loading
      if (rsp_tvalid_ff && rsp_tready && !(state_ff == ST_RESP))
         rsp_tvalid_in = 1'b0;
   end

   // control and camera state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff <= MOP_STEP;
         comp_ff <= 2'd0;  vec_ff <= 2'd0;  iter_ff <= '0;
         sel_ff <= 1'b0;   flip_ff <= 1'b0;
         speed_ff <= SPEED_RESET;
         sens_ff  <= SENS_RESET;
         pos_ff   <= '{default: 32'sd0};
         yaw_ff   <= YAW_RESET;
         pitch_ff <= 16'sd0;
         basis_ff <= '{16'sd0, 16'sd0, -UNIT_Q14, UNIT_Q14, 16'sd0, 16'sd0,
                       16'sd0, UNIT_Q14, 16'sd0};
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         comp_ff <= comp_in;  vec_ff <= vec_in;  iter_ff <= iter_in;
         sel_ff <= sel_in;    flip_ff <= flip_in;
         if (csr_wr && csr_paddr[2] == REG_MOVE_SPEED)
            speed_ff <= csr_pwdata[15:0];
         if (csr_wr && csr_paddr[2] == REG_LOOK_SENS)
            sens_ff <= csr_pwdata[15:0];
         pos_ff   <= pos_in;
         yaw_ff   <= yaw_in;
         pitch_ff <= pitch_in;
         basis_ff <= basis_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      dir_ff <= dir_in;  dx_ff <= dx_in;  dy_ff <= dy_in;  t_ff <= t_in;
      step_ff <= step_in;  prod_ff <= prod_in;  acc_ff <= acc_in;  tmp_ff <= tmp_in;
      offx_ff <= offx_in;  offy_ff <= offy_in;
      sy_ff <= sy_in;  cy_ff <= cy_in;  sp_ff <= sp_in;  cp_ff <= cp_in;
      crx_ff <= crx_in;  cry_ff <= cry_in;  crz_ff <= crz_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   `EFCU_ASSERT_NOW(a_pitch_range, clock, reset, 1'b1, pitch_ff <= 16'sd22784 && pitch_ff >= -16'sd22784)
   `EFCU_ASSERT_NOW(a_yaw_range, clock, reset, 1'b1, yaw_ff <= 18'sd92160 && yaw_ff >= -18'sd92160)
   `EFCU_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

`default_nettype wire

// ===== tb/tb_euler_fly_camera_update_unit.sv =====
// Self-checking testbench for the fly camera update unit: random and directed frame items,
// register changes between phases, random stalls on both streams.
// Depends on efcu_pkg and the euler_fly_camera_update_unit RTL.
`timescale 1ns / 1ps

module tb_euler_fly_camera_update_unit;
   import efcu_pkg::*;

   localparam int N_RANDOM = 640;

   // register byte addresses
   localparam logic [2:0] ADDR_MOVE_SPEED = {REG_MOVE_SPEED, 2'b00};
   localparam logic [2:0] ADDR_LOOK_SENS  = {REG_LOOK_SENS, 2'b00};

   // one frame item as driven on req_tdata
   typedef struct packed {
      logic [15:0] frame_time;
      logic [15:0] mouse_dy;
      logic [15:0] mouse_dx;
      logic [1:0]  rise;
      logic [1:0]  strafe;
      logic [1:0]  fwd;
   } frame_item_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [55:0]   req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [231:0]  rsp_tdata;
   logic          csr_psel = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite = 1'b0;
   logic [2:0]    csr_paddr = '0;
   logic [31:0]   csr_pwdata = '0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   euler_fly_camera_update_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // camera model state
   longint cam_pos[3];
   longint cam_yaw, cam_pitch;
   longint cam_basis[9];
   longint speed_reg, sens_reg;

   frame_item_type pending_frames[$];
   logic [231:0]   expected_states[$];
   int             mismatches = 0;
   bit             stimulus_done = 1'b0;
   bit             hold_off = 1'b0;

   function automatic longint floor_sh(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_sh(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clamp_q14(longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
   endfunction

   function automatic longint q14_product(longint a, longint b);
      return clamp_q14(round_sh(a * b, 14));
   endfunction

   function automatic longint axis_sign(logic [1:0] a);
      return (a == 2'b01) ? 1 : ((a == 2'b00) ? 0 : -1);
   endfunction

   // sine and cosine (Q1.14) of an angle in Q.8 degrees
   task automatic sin_cos(input longint deg, output longint s, output longint c);
      longint z, x, y, nx, xs, ys;
      longint atan_v[24];
      bit flip;
      atan_v = '{2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
                 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
      z = deg * 256;
      x = 652032874;
      y = 0;
      flip = 1'b0;
      if (z > 11796480) z -= 23592960;
      else if (z < -11796480) z += 23592960;
      if (z > 5898240) begin
         z -= 11796480;
         flip = 1'b1;
      end else if (z < -5898240) begin
         z += 11796480;
         flip = 1'b1;
      end
      for (int i = 0; i < CordicIters; i++) begin
         xs = floor_sh(x, i);
         ys = floor_sh(y, i);
         if (z >= 0) begin
            nx = x - ys; y = y + xs; z -= atan_v[i];
         end else begin
            nx = x + ys; y = y - xs; z += atan_v[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = clamp_q14(round_sh(x, 16));
      s = clamp_q14(round_sh(y, 16));
   endtask

   task automatic camera_reset();
      speed_reg = SPEED_RESET;
      sens_reg = SENS_RESET;
      cam_pos = '{0, 0, 0};
      cam_yaw = -23040;
      cam_pitch = 0;
      cam_basis = '{0, 0, -16384, 16384, 0, 0, 0, 16384, 0};
   endtask

   // advance the camera by one frame and queue the resulting state
   task automatic camera_step(input frame_item_type f);
      longint dirs[3], stp, t, sum, offx, offy, p, yw, sy, cy, sp, cp;
      logic [231:0] r;
      dirs[0] = axis_sign(f.fwd);
      dirs[1] = axis_sign(f.strafe);
      dirs[2] = axis_sign(f.rise);
      t = f.frame_time;
      stp = speed_reg * t;
      for (int k = 0; k < 3; k++) begin
         sum = cam_pos[k];
         for (int v = 0; v < 3; v++)
            sum += dirs[v] * round_sh(stp * cam_basis[v * 3 + k], 22);
         if (sum > 64'sd2147483647) sum = 64'sd2147483647;
         else if (sum < -64'sd2147483648) sum = -64'sd2147483648;
         cam_pos[k] = sum;
      end
      offx = round_sh(longint'($signed(f.mouse_dx)) * sens_reg * t, 16);
      offy = round_sh(longint'($signed(f.mouse_dy)) * sens_reg * t, 16);
      p = cam_pitch - offy;
      if (p > 22784) p = 22784;
      else if (p < -22784) p = -22784;
      yw = cam_yaw + offx;
      if (yw > 92160 || yw < -92160) yw = 0;
      cam_pitch = p;
      cam_yaw = yw;
      sin_cos(cam_yaw, sy, cy);
      sin_cos(cam_pitch, sp, cp);
      cam_basis = '{q14_product(cy, cp), sp, q14_product(sy, cp), -sy, 0, cy,
                    -q14_product(cy, sp), cp, -q14_product(sy, sp)};
      r = '0;
      r[31:0] = cam_pos[0][31:0];
      r[63:32] = cam_pos[1][31:0];
      r[95:64] = cam_pos[2][31:0];
      r[111:96] = cam_basis[0][15:0];
      r[127:112] = cam_basis[1][15:0];
      r[143:128] = cam_basis[2][15:0];
      r[159:144] = cam_basis[6][15:0];
      r[175:160] = cam_basis[7][15:0];
      r[191:176] = cam_basis[8][15:0];
      r[209:192] = cam_yaw[17:0];
      r[225:210] = cam_pitch[15:0];
      expected_states.push_back(r);
   endtask

   // APB write: setup then access cycle
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_MOVE_SPEED) speed_reg = data[15:0];
      else if (addr == ADDR_LOOK_SENS) sens_reg = data[15:0];
   endtask

   function automatic frame_item_type random_frame();
      frame_item_type f;
      logic [63:0] rnd;
      rnd = {$urandom, $urandom};
      f = rnd[53:0];
      case ($urandom_range(0, 3))
         0: f.frame_time = 16'($urandom_range(0, 2000));
         1: begin
            f.mouse_dx = 16'(int'($urandom_range(0, 200)) - 100);
            f.mouse_dy = 16'(int'($urandom_range(0, 200)) - 100);
         end
         default: ;
      endcase
      return f;
   endfunction

   task automatic add_frame(input frame_item_type f);
      pending_frames.push_back(f);
   endtask

   task automatic drain_phase();
      while (pending_frames.size() != 0 || expected_states.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // sender: one item at a time from pending_frames
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            camera_step(frame_item_type'(req_tdata[53:0]));
            send_gap = $urandom_range(0, 8);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap == 0 && pending_frames.size() != 0) begin
               req_tdata <= {2'b00, pending_frames.pop_front()};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
               if (send_gap > 0)
                  send_gap--;
            end
         end
      end
   end

   // receiver: random stall per item, plus an explicit long hold-off
   int recv_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_states.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
            end else if (expected_states[0] !== rsp_tdata) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp %h got %h", expected_states[0], rsp_tdata);
               void'(expected_states.pop_front());
            end else
               void'(expected_states.pop_front());
            recv_gap = $urandom_range(0, 8);
         end
         if (recv_gap > 0) recv_gap--;
         rsp_tready <= !hold_off && (recv_gap == 0);
      end
   end

   // long receiver hold-off while the sender keeps offering items
   initial begin
      int stall_cycles;
      wait (stimulus_done == 1'b0 && !reset);
      while (pending_frames.size() < 100)
         @(posedge clock);
      repeat (200) @(posedge clock);
      hold_off = 1'b1;
      stall_cycles = 0;
      while (stall_cycles < 600) begin
         @(posedge clock);
         stall_cycles++;
      end
      hold_off = 1'b0;
   end

   initial begin
      frame_item_type f;
      camera_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every axis code, pitch clamp, yaw wrap, idle frames
      f = '0; add_frame(f);
      f = '{16'hFFFF, 16'h7FFF, 16'h8000, 2'b01, 2'b01, 2'b01}; add_frame(f);
      f = '{16'hFFFF, 16'h8000, 16'h7FFF, 2'b11, 2'b11, 2'b11}; add_frame(f);
      f = '{16'hFFFF, 16'h0000, 16'h7FFF, 2'b10, 2'b10, 2'b10}; add_frame(f);
      f = '{16'h8000, 16'h0000, 16'h0000, 2'b00, 2'b01, 2'b11}; add_frame(f);
      f = '{16'h0000, 16'h1234, 16'h4321, 2'b01, 2'b00, 2'b10}; add_frame(f);
      f = '{16'h0400, 16'hFFFF, 16'h0001, 2'b11, 2'b10, 2'b01}; add_frame(f);
      for (int i = 0; i < 8; i++) begin
         f = '{16'h2000, 16'h0000, 16'h0200, 2'b01, 2'b01, 2'b01}; add_frame(f);
      end
      drain_phase();

      // top speed, zero sensitivity
      csr_write(ADDR_MOVE_SPEED, 32'hFFFF_FFFF);
      csr_write(ADDR_LOOK_SENS, 32'h0000_0000);
      for (int i = 0; i < 10; i++) begin
         f = '{16'hFFFF, 16'h0000, 16'h0000, 2'b00, 2'b00, 2'b01}; add_frame(f);
      end
      drain_phase();

      // random phases with varied register settings
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               csr_write(ADDR_MOVE_SPEED, 32'd5120); csr_write(ADDR_LOOK_SENS, 32'hFFFF);
            end
            1: begin
               csr_write(ADDR_MOVE_SPEED, 32'd0); csr_write(ADDR_LOOK_SENS, 32'd6400);
            end
            2: begin
               csr_write(ADDR_MOVE_SPEED, $urandom); csr_write(ADDR_LOOK_SENS, $urandom);
            end
            default: begin
               csr_write(ADDR_MOVE_SPEED, 32'd256); csr_write(ADDR_LOOK_SENS, 32'd1);
            end
         endcase
         for (int i = 0; i < N_RANDOM / 4; i++) add_frame(random_frame());
         drain_phase();
      end
      stimulus_done = 1'b1;
      if (mismatches == 0 && expected_states.size() == 0)
         $display("PASS euler_fly_camera_update_unit");
      else
         $display("FAIL euler_fly_camera_update_unit");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL euler_fly_camera_update_unit");
      $finish;
   end
endmodule
